[rtl/core/sqs_pkg.sv]
package sqs_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned HW_W = 31;
    localparam int unsigned MINLEN_W = 63;
    localparam int unsigned MAG_W = 31;
    localparam int unsigned RHS_W = 126;
    localparam int unsigned ACC_W = 128;

    localparam logic [0:0] REG_HALF_WIDTH = 1'b0;
    localparam logic [0:0] REG_MIN_LENGTH_SQ = 1'b1;

    localparam logic [3:0] OP_HW2 = 4'd0;
    localparam logic [3:0] OP_AX = 4'd1;
    localparam logic [3:0] OP_AY = 4'd2;
    localparam logic [3:0] OP_AZ = 4'd3;
    localparam logic [3:0] OP_X_LL = 4'd4;
    localparam logic [3:0] OP_X_LH = 4'd5;
    localparam logic [3:0] OP_X_HL = 4'd6;
    localparam logic [3:0] OP_X_HH = 4'd7;
    localparam logic [3:0] OP_Y_LL = 4'd8;
    localparam logic [3:0] OP_Y_LH = 4'd9;
    localparam logic [3:0] OP_Y_HL = 4'd10;
    localparam logic [3:0] OP_Y_HH = 4'd11;
    localparam logic [3:0] MUL_OPS = 4'd12;

    localparam logic [4:0] TOP_BIT = 5'd30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_TEST,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic search_init;
        logic search_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic mul_last;
        logic len_pass;
        logic search_last;
        logic out_busy;
    } status_t;

    function automatic logic [COORD_W-1:0] sat34(input logic signed [33:0] v);
        logic [COORD_W-1:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/segment_to_quad_strip.sv]
// Turns each accepted 3D segment word into one quad word of a thick 2D strip, or into
// nothing when the squared segment length is not above min_length_sq. Before the next item
// can be accepted, an item passes through these steps in order: the one shared 32x32
// multiplier forms the squares and the scaled right-hand sides, the length is tested,
// 31 steps of the bitwise offset search run and the output register is written once
// it is free. A skipped segment ends after the length test. A finished quad waits in the
// output register while the next segment is accepted and worked on.
module segment_to_quad_strip #(
    parameter int FRAC_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [0:0]    cfg_addr,
    input  logic [62:0]   cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [191:0]  s_tdata,
    // new_strip
    input  logic [0:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y
    output logic [255:0]  m_tdata
);

    sqs_pkg::cmd_t    cmd;
    sqs_pkg::status_t status;

    sqs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sqs_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[rtl/core/sqs_search.sv]
module sqs_search (
    input  logic                            aclk,
    input  logic                            init,
    input  logic                            step,
    input  logic [4:0]                      bit_idx,
    input  logic [sqs_pkg::RHS_W-1:0]       rhs,
    input  logic [sqs_pkg::ACC_W-1:0]       ss,
    output logic [sqs_pkg::MAG_W-1:0]       mag
);

    logic [sqs_pkg::ACC_W-1:0] p_reg;
    logic [sqs_pkg::ACC_W-1:0] qs_reg;
    logic [sqs_pkg::MAG_W-1:0] t_reg;
    logic [sqs_pkg::ACC_W-1:0] cand;
    logic                      take;

    // The trial square times the planar length is built from running terms:
    // (t + 2^b)^2 * S = t^2 * S + (t * S) << (b + 1) + S << 2b.
    assign cand = p_reg + qs_reg + ss;
    assign take = cand <= {2'b00, rhs};

    always_ff @(posedge aclk) begin
        if (init) begin
            p_reg <= '0;
            qs_reg <= '0;
            t_reg <= '0;
        end else if (step) begin
            if (take) begin
                p_reg <= cand;
                t_reg[bit_idx] <= 1'b1;
                qs_reg <= (qs_reg >> 1) + ss;
            end else begin
                qs_reg <= qs_reg >> 1;
            end
        end
    end

    assign mag = t_reg;

endmodule

[rtl/core/sqs_ctrl.sv]
module sqs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sqs_pkg::status_t  status,
    output sqs_pkg::cmd_t     cmd
);

    sqs_pkg::state_t state_reg;
    sqs_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sqs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sqs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sqs_pkg::ST_MUL;
                end
            end
            sqs_pkg::ST_MUL: begin
                if (status.mul_last) begin
                    state_next = sqs_pkg::ST_TEST;
                end
            end
            sqs_pkg::ST_TEST: begin
                state_next = status.len_pass ? sqs_pkg::ST_SEARCH : sqs_pkg::ST_IDLE;
            end
            sqs_pkg::ST_SEARCH: begin
                if (status.search_last) begin
                    state_next = sqs_pkg::ST_FINISH;
                end
            end
            sqs_pkg::ST_FINISH: begin
                if (!status.out_busy) begin
                    state_next = sqs_pkg::ST_IDLE;
                end
            end
            default: state_next = sqs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            sqs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            sqs_pkg::ST_MUL: cmd.mul_step = 1'b1;
            sqs_pkg::ST_TEST: cmd.search_init = 1'b1;
            sqs_pkg::ST_SEARCH: cmd.search_step = 1'b1;
            sqs_pkg::ST_FINISH: cmd.emit = !status.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule

[rtl/core/sqs_dp.sv]
module sqs_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [0:0]                       cfg_addr,
    input  logic [sqs_pkg::MINLEN_W-1:0]     cfg_wdata,
    input  logic [191:0]                     s_tdata,
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [255:0]                     m_tdata,
    input  sqs_pkg::cmd_t                    cmd,
    output sqs_pkg::status_t                 status
);

    localparam logic [63:0] HW_RST64 = 64'd1 << (FRAC_BITS - 1);
    localparam logic [63:0] MIN_RST64 = ((64'd1 << (2 * FRAC_BITS)) + 64'd50) / 64'd100;

    logic [sqs_pkg::HW_W-1:0]     hw_reg;
    logic [sqs_pkg::MINLEN_W-1:0] min_reg;

    logic signed [31:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [31:0]        ax_reg, ay_reg, az_reg;
    logic               dx_neg_reg, dy_neg_reg;
    logic               have_prev_reg;
    logic [31:0]        p2x_reg, p2y_reg, p3x_reg, p3y_reg;

    logic [3:0]         mul_cnt_reg;
    logic [63:0]        prod_reg;
    logic [61:0]        hw2_reg;
    logic [63:0]        sx_reg, sy_reg, sz_reg;
    logic [sqs_pkg::RHS_W-1:0] rhs_x_reg, rhs_y_reg;
    logic [64:0]        s_reg;
    logic [sqs_pkg::ACC_W-1:0] ss_reg;
    logic [4:0]         bit_reg;

    logic               m_tvalid_reg;
    logic [255:0]       m_tdata_reg;

    logic signed [32:0] dx_in, dy_in, dz_in;
    logic [31:0]        op_a, op_b;
    logic [3:0]         acc_op;
    logic [64:0]        sum1, sum2;
    logic [63:0]        len1, len_sq;
    logic [sqs_pkg::MAG_W-1:0] tx, ty, mx, my;
    logic signed [33:0] hx, hy, x0e, y0e, x1e, y1e;
    logic [31:0]        c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hw_reg <= HW_RST64[sqs_pkg::HW_W-1:0];
            min_reg <= MIN_RST64[sqs_pkg::MINLEN_W-1:0];
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                sqs_pkg::REG_HALF_WIDTH: hw_reg <= cfg_wdata[sqs_pkg::HW_W-1:0];
                sqs_pkg::REG_MIN_LENGTH_SQ: min_reg <= cfg_wdata;
                default: hw_reg <= hw_reg;
            endcase
        end
    end

    assign dx_in = $signed({s_tdata[127], s_tdata[127:96]})
                 - $signed({s_tdata[31], s_tdata[31:0]});
    assign dy_in = $signed({s_tdata[159], s_tdata[159:128]})
                 - $signed({s_tdata[63], s_tdata[63:32]});
    assign dz_in = $signed({s_tdata[191], s_tdata[191:160]})
                 - $signed({s_tdata[95], s_tdata[95:64]});

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x0_reg <= s_tdata[31:0];
            y0_reg <= s_tdata[63:32];
            x1_reg <= s_tdata[127:96];
            y1_reg <= s_tdata[159:128];
            ax_reg <= dx_in[32] ? 32'(-dx_in) : dx_in[31:0];
            ay_reg <= dy_in[32] ? 32'(-dy_in) : dy_in[31:0];
            az_reg <= dz_in[32] ? 32'(-dz_in) : dz_in[31:0];
            dx_neg_reg <= dx_in[32];
            dy_neg_reg <= dy_in[32];
        end
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (mul_cnt_reg)
            sqs_pkg::OP_HW2: begin op_a = {1'b0, hw_reg}; op_b = {1'b0, hw_reg}; end
            sqs_pkg::OP_AX: begin op_a = ax_reg; op_b = ax_reg; end
            sqs_pkg::OP_AY: begin op_a = ay_reg; op_b = ay_reg; end
            sqs_pkg::OP_AZ: begin op_a = az_reg; op_b = az_reg; end
            sqs_pkg::OP_X_LL: begin op_a = hw2_reg[31:0]; op_b = sy_reg[31:0]; end
            sqs_pkg::OP_X_LH: begin op_a = hw2_reg[31:0]; op_b = sy_reg[63:32]; end
            sqs_pkg::OP_X_HL: begin op_a = {2'b00, hw2_reg[61:32]}; op_b = sy_reg[31:0]; end
            sqs_pkg::OP_X_HH: begin op_a = {2'b00, hw2_reg[61:32]}; op_b = sy_reg[63:32]; end
            sqs_pkg::OP_Y_LL: begin op_a = hw2_reg[31:0]; op_b = sx_reg[31:0]; end
            sqs_pkg::OP_Y_LH: begin op_a = hw2_reg[31:0]; op_b = sx_reg[63:32]; end
            sqs_pkg::OP_Y_HL: begin op_a = {2'b00, hw2_reg[61:32]}; op_b = sx_reg[31:0]; end
            sqs_pkg::OP_Y_HH: begin op_a = {2'b00, hw2_reg[61:32]}; op_b = sx_reg[63:32]; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign acc_op = mul_cnt_reg - 4'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_cnt_reg <= '0;
        end else if (cmd.load) begin
            mul_cnt_reg <= '0;
        end else if (cmd.mul_step && mul_cnt_reg != sqs_pkg::MUL_OPS) begin
            mul_cnt_reg <= mul_cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rhs_x_reg <= '0;
            rhs_y_reg <= '0;
        end else if (cmd.mul_step) begin
            if (mul_cnt_reg != sqs_pkg::MUL_OPS) begin
                prod_reg <= 64'(op_a) * 64'(op_b);
            end
            if (mul_cnt_reg != 4'd0) begin
                unique case (acc_op)
                    sqs_pkg::OP_HW2: hw2_reg <= prod_reg[61:0];
                    sqs_pkg::OP_AX: sx_reg <= prod_reg;
                    sqs_pkg::OP_AY: sy_reg <= prod_reg;
                    sqs_pkg::OP_AZ: sz_reg <= prod_reg;
                    sqs_pkg::OP_X_LL: rhs_x_reg <= rhs_x_reg + {62'd0, prod_reg};
                    sqs_pkg::OP_X_LH,
                    sqs_pkg::OP_X_HL: rhs_x_reg <= rhs_x_reg + {30'd0, prod_reg, 32'd0};
                    sqs_pkg::OP_X_HH: rhs_x_reg <= rhs_x_reg + {prod_reg[61:0], 64'd0};
                    sqs_pkg::OP_Y_LL: rhs_y_reg <= rhs_y_reg + {62'd0, prod_reg};
                    sqs_pkg::OP_Y_LH,
                    sqs_pkg::OP_Y_HL: rhs_y_reg <= rhs_y_reg + {30'd0, prod_reg, 32'd0};
                    sqs_pkg::OP_Y_HH: rhs_y_reg <= rhs_y_reg + {prod_reg[61:0], 64'd0};
                    default: rhs_y_reg <= rhs_y_reg;
                endcase
            end
        end
    end

    assign sum1 = {1'b0, sx_reg} + {1'b0, sy_reg};
    assign len1 = sum1[64] ? '1 : sum1[63:0];
    assign sum2 = {1'b0, len1} + {1'b0, sz_reg};
    assign len_sq = sum2[64] ? '1 : sum2[63:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= '0;
        end else if (cmd.search_init) begin
            bit_reg <= sqs_pkg::TOP_BIT;
        end else if (cmd.search_step && bit_reg != 5'd0) begin
            bit_reg <= bit_reg - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.search_init) begin
            s_reg <= sum1;
            ss_reg <= {3'b000, sum1, 60'd0};
        end else if (cmd.search_step) begin
            ss_reg <= ss_reg >> 2;
        end
    end

    sqs_search u_search_x (
        .aclk    (aclk),
        .init    (cmd.search_init),
        .step    (cmd.search_step),
        .bit_idx (bit_reg),
        .rhs     (rhs_x_reg),
        .ss      (ss_reg),
        .mag     (tx)
    );

    sqs_search u_search_y (
        .aclk    (aclk),
        .init    (cmd.search_init),
        .step    (cmd.search_step),
        .bit_idx (bit_reg),
        .rhs     (rhs_y_reg),
        .ss      (ss_reg),
        .mag     (ty)
    );

    assign mx = (s_reg == '0) ? '0 : tx;
    assign my = (s_reg == '0) ? '0 : ty;
    assign hx = dy_neg_reg ? -$signed({3'b000, mx}) : $signed({3'b000, mx});
    assign hy = dx_neg_reg ? $signed({3'b000, my}) : -$signed({3'b000, my});
    assign x0e = {{2{x0_reg[31]}}, x0_reg};
    assign y0e = {{2{y0_reg[31]}}, y0_reg};
    assign x1e = {{2{x1_reg[31]}}, x1_reg};
    assign y1e = {{2{y1_reg[31]}}, y1_reg};

    assign c0x = have_prev_reg ? p3x_reg : sqs_pkg::sat34(x0e - hx);
    assign c0y = have_prev_reg ? p3y_reg : sqs_pkg::sat34(y0e - hy);
    assign c1x = have_prev_reg ? p2x_reg : sqs_pkg::sat34(x0e + hx);
    assign c1y = have_prev_reg ? p2y_reg : sqs_pkg::sat34(y0e + hy);
    assign c2x = sqs_pkg::sat34(x1e + hx);
    assign c2y = sqs_pkg::sat34(y1e + hy);
    assign c3x = sqs_pkg::sat34(x1e - hx);
    assign c3y = sqs_pkg::sat34(y1e - hy);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.load && s_tuser[0]) begin
                have_prev_reg <= 1'b0;
            end else if (cmd.emit) begin
                have_prev_reg <= 1'b1;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2x_reg <= '0;
            p2y_reg <= '0;
            p3x_reg <= '0;
            p3y_reg <= '0;
        end else if (cmd.emit) begin
            p2x_reg <= c2x;
            p2y_reg <= c2y;
            p3x_reg <= c3x;
            p3y_reg <= c3y;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {c3y, c3x, c2y, c2x, c1y, c1x, c0y, c0x};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    assign status.mul_last = mul_cnt_reg == sqs_pkg::MUL_OPS;
    assign status.len_pass = len_sq > {1'b0, min_reg};
    assign status.search_last = bit_reg == 5'd0;
    assign status.out_busy = m_tvalid_reg && !m_tready;

endmodule
